### rtl/l2lh_pkg.sv
// Shared widths and constants for the log2 latency histogram.
package l2lh_pkg;

    localparam int BUCKETS_DEF = 32;   // default number of log2 buckets
    localparam int LAT_W       = 32;   // latency and counter width
    localparam int PCT_W       = 7;    // percentile field width
    localparam int SUM_W       = 64;   // running latency total width
    localparam int BOUND_W     = 33;   // percentile bound width
    localparam int RANK_SCALE  = 100;  // percent scale of the rank compare
    localparam int SCALE_W     = 7;    // bits that hold RANK_SCALE

endpackage

### rtl/log2_latency_histogram_top.sv
// Latency monitor with a log2 bucket histogram, mean and percentile bound.
//
// Channels:
//   input  : i_in_valid / o_in_ready, one transaction per record or query
//            (i_action 0 = record i_latency_ms, 1 = query with i_percentile).
//   output : o_out_valid / i_out_ready, one transaction per query only.
//   config : i_cfg_valid / o_cfg_ready writes i_cfg_enable; always ready.
// Records are dropped while enable is 0; queries are always answered.
// One item is worked on at a time by a small sequencer around a single
// bucket memory (one write port, one read port) and a bit-serial divider.
//   record : halve to find the bucket index, read the bucket, write it back.
//   query  : setup, then per bucket walked a memory read, scale by 100,
//            accumulate and compare; then 32 divide steps, skipped when the
//            mean saturates, and the result load; an empty one loads at once.
// The walk stops at the first bucket that reaches the target rank.
// Reset clears the counters, the enable bit and every bucket valid bit at
// once; no clearing pass is needed. While a result waits on a stalled
// receiver the block still accepts the next transaction; a following query
// holds in its last state until the output register frees up.
module log2_latency_histogram_top #(
    parameter int BUCKETS = l2lh_pkg::BUCKETS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_enable,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [l2lh_pkg::LAT_W-1:0]   i_latency_ms,
    input  logic [l2lh_pkg::PCT_W-1:0]   i_percentile,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [l2lh_pkg::LAT_W-1:0]   o_sample_count,
    output logic [l2lh_pkg::LAT_W-1:0]   o_mean_ms,
    output logic [l2lh_pkg::BOUND_W-1:0] o_percentile_bound_ms,
    output logic [l2lh_pkg::LAT_W-1:0]   o_max_ms
);

    localparam int LAT_W   = l2lh_pkg::LAT_W;
    localparam int PCT_W   = l2lh_pkg::PCT_W;
    localparam int SUM_W   = l2lh_pkg::SUM_W;
    localparam int BOUND_W = l2lh_pkg::BOUND_W;
    localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    // rank x 100 compare: x = samples * percentile, seen100 = 100 * running total
    localparam int X_W     = LAT_W + PCT_W;
    localparam int SEEN_W  = LAT_W + IDX_W + l2lh_pkg::SCALE_W;
    localparam int CNT_W   = $clog2(LAT_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REC_LOG,
        S_REC_RD,
        S_REC_WR,
        S_Q_MUL,
        S_Q_RD,
        S_Q_SCALE,
        S_Q_ACC,
        S_Q_CHK,
        S_Q_DIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_enable;
    logic [LAT_W-1:0]        r_samples;
    logic [SUM_W-1:0]        r_sum;
    logic [LAT_W-1:0]        r_peak;
    logic [BUCKETS-1:0]      r_bvalid;

    // bucket memory with registered read
    logic [LAT_W-1:0]        r_mem [BUCKETS];
    logic [LAT_W-1:0]        r_rdata;
    logic                    r_rvalid;

    // sequencer working registers
    logic [IDX_W-1:0]        r_idx;
    logic [LAT_W-1:0]        r_work;
    logic [PCT_W-1:0]        r_pct;
    logic [X_W-1:0]          r_x;
    logic [SEEN_W-1:0]       r_b100;
    logic [SEEN_W-1:0]       r_seen100;
    logic                    r_sat;
    logic [LAT_W-1:0]        r_rem;
    logic [LAT_W-1:0]        r_dlo;
    logic [CNT_W-1:0]        r_cnt;
    logic [BOUND_W-1:0]      r_bound;

    // output register
    logic                    r_out_valid;
    logic [LAT_W-1:0]        r_o_count;
    logic [LAT_W-1:0]        r_o_mean;
    logic [BOUND_W-1:0]      r_o_bound;
    logic [LAT_W-1:0]        r_o_max;

    logic                    w_in_acc;
    logic [LAT_W-1:0]        w_bucket;
    logic [LAT_W:0]          w_rem_sh;
    logic [LAT_W:0]          w_diff;
    logic                    w_ge;
    logic [BOUND_W-1:0]      w_step_bound;
    logic                    w_hit;
    logic                    w_last;
    logic                    w_out_free;
    logic                    w_out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // a bucket never written reads as zero
    assign w_bucket = r_rvalid ? r_rdata : '0;

    // one restoring divide step: shift in the next dividend bit, trial subtract
    assign w_rem_sh = {r_rem, r_dlo[LAT_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_samples};
    assign w_ge     = (w_rem_sh >= {1'b0, r_samples});

    // bucket i covers up to 2^(i+1); saturate at 2^32
    always_comb begin
        if (32'(r_idx) >= 32'(LAT_W - 1)) begin
            w_step_bound = BOUND_W'(1) << LAT_W;
        end else begin
            w_step_bound = BOUND_W'(1) << (32'(r_idx) + 32'd1);
        end
    end

    // rank reached: 100*seen >= samples*pct, and seen at least one
    assign w_hit  = (r_seen100 >= SEEN_W'(r_x)) && (r_seen100 != '0);
    assign w_last = (r_idx == IDX_W'(BUCKETS - 1));

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    // bucket memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_REC_WR) begin
            r_mem[r_idx] <= w_bucket + LAT_W'(1);
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_samples   <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_bvalid    <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid <= r_bvalid[r_idx];

            if (i_cfg_valid) begin
                r_enable <= i_cfg_enable;
            end

            // load a new result, or drop the old one once taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_idx <= '0;
                        if (i_action == 1'b0) begin
                            // record: statistics now, bucket through the sequencer
                            if (r_enable) begin
                                r_samples <= r_samples + LAT_W'(1);
                                r_sum     <= r_sum + SUM_W'(i_latency_ms);
                                if (i_latency_ms > r_peak) begin
                                    r_peak <= i_latency_ms;
                                end
                                r_work  <= i_latency_ms;
                                r_state <= S_REC_LOG;
                            end
                        end else begin
                            // query: set up the divider and the rank walk
                            r_pct   <= i_percentile;
                            r_sat   <= (r_sum[SUM_W-1:LAT_W] >= r_samples);
                            r_rem   <= r_sum[SUM_W-1:LAT_W];
                            r_dlo   <= r_sum[LAT_W-1:0];
                            r_cnt   <= '0;
                            r_bound <= '0;
                            if (r_samples == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_Q_MUL;
                            end
                        end
                    end
                end

                S_REC_LOG: begin
                    // halve until one is left or the last bucket is reached, one bit per cycle
                    if ((r_work > LAT_W'(1)) && !w_last) begin
                        r_work <= r_work >> 1;
                        r_idx  <= r_idx + IDX_W'(1);
                    end else begin
                        r_state <= S_REC_RD;
                    end
                end

                S_REC_RD: begin
                    r_state <= S_REC_WR;
                end

                S_REC_WR: begin
                    r_bvalid[r_idx] <= 1'b1;
                    r_state         <= S_IDLE;
                end

                S_Q_MUL: begin
                    r_x       <= X_W'(r_samples) * X_W'(r_pct);
                    r_seen100 <= '0;
                    r_idx     <= '0;
                    r_state   <= S_Q_RD;
                end

                S_Q_RD: begin
                    r_state <= S_Q_SCALE;
                end

                S_Q_SCALE: begin
                    r_b100  <= SEEN_W'(w_bucket) * SEEN_W'(l2lh_pkg::RANK_SCALE);
                    r_state <= S_Q_ACC;
                end

                S_Q_ACC: begin
                    r_seen100 <= r_seen100 + r_b100;
                    r_state   <= S_Q_CHK;
                end

                S_Q_CHK: begin
                    if (w_hit || w_last) begin
                        r_bound <= w_hit ? w_step_bound : BOUND_W'(r_peak);
                        r_state <= r_sat ? S_DONE : S_Q_DIV;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_Q_RD;
                    end
                end

                S_Q_DIV: begin
                    r_rem <= w_ge ? w_diff[LAT_W-1:0] : w_rem_sh[LAT_W-1:0];
                    r_dlo <= {r_dlo[LAT_W-2:0], w_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(LAT_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // hold until the output register frees up
                    if (w_out_free) begin
                        r_o_count   <= r_samples;
                        r_o_max     <= r_peak;
                        r_o_bound   <= r_bound;
                        if (r_samples == '0) begin
                            r_o_mean <= '0;
                        end else if (r_sat) begin
                            r_o_mean <= '1;
                        end else begin
                            r_o_mean <= r_dlo;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_sample_count        = r_o_count;
    assign o_mean_ms             = r_o_mean;
    assign o_percentile_bound_ms = r_o_bound;
    assign o_max_ms              = r_o_max;

endmodule

### sim/testbench.sv
// Testbench for the log2 latency histogram: directed and random traffic checked by a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int               LAT_W        = l2lh_pkg::LAT_W;
    localparam int               PCT_W        = l2lh_pkg::PCT_W;
    localparam int               SUM_W        = l2lh_pkg::SUM_W;
    localparam int               BOUND_W      = l2lh_pkg::BOUND_W;
    localparam int               RANK_SCALE   = l2lh_pkg::RANK_SCALE;
    localparam int               BUCKETS      = l2lh_pkg::BUCKETS_DEF;
    localparam logic             ACT_RECORD   = 1'b0;
    localparam logic             ACT_QUERY    = 1'b1;
    localparam logic             ENABLE_OFF   = 1'b0;
    localparam logic             ENABLE_ON    = 1'b1;
    localparam logic [LAT_W-1:0] LAT_MAX      = '1;
    // Drain time after the last answer; leaves margin over a full bucket walk plus divide.
    localparam int               DRAIN_CYCLES = 250;
    localparam int               CYCLE_LIMIT  = 1_500_000;

    // One transaction on the input channel.
    typedef struct {
        logic             action;
        logic [LAT_W-1:0] latency;
        logic [PCT_W-1:0] pct;
    } t_item;

    // One query answer.
    typedef struct {
        logic [LAT_W-1:0]   count;
        logic [LAT_W-1:0]   mean;
        logic [BOUND_W-1:0] bound;
        logic [LAT_W-1:0]   peak;
    } t_stats;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_CHOKED} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_enable;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic [LAT_W-1:0]   i_latency_ms;
    logic [PCT_W-1:0]   i_percentile;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [LAT_W-1:0]   o_sample_count;
    logic [LAT_W-1:0]   o_mean_ms;
    logic [BOUND_W-1:0] o_percentile_bound_ms;
    logic [LAT_W-1:0]   o_max_ms;

    // Predicted histogram state, kept in step with accepted transactions.
    logic [LAT_W-1:0] hist_bins [BUCKETS];
    logic [LAT_W-1:0] hist_samples;
    logic [SUM_W-1:0] hist_total;
    logic [LAT_W-1:0] hist_peak;
    logic             hist_enable;

    t_item    send_queue[$];     // transactions waiting for the driver
    t_stats   stats_due[$];      // answers owed by the block, oldest first
    t_item    next_item;
    t_stats   want_stats;
    int       items_queued   = 0;
    int       items_accepted = 0;
    int       errors         = 0;
    int       cycle_count    = 0;
    bit       in_taken       = 1'b0;
    int       burst_left     = 1;
    int       gap_left       = 0;
    t_rx_mode rx_mode        = RX_OPEN;
    int       rx_left        = 0;

    log2_latency_histogram_top #(
        .BUCKETS(BUCKETS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_enable         (i_cfg_enable),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_action             (i_action),
        .i_latency_ms         (i_latency_ms),
        .i_percentile         (i_percentile),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_sample_count       (o_sample_count),
        .o_mean_ms            (o_mean_ms),
        .o_percentile_bound_ms(o_percentile_bound_ms),
        .o_max_ms             (o_max_ms)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Map a latency to its log2 bucket: 0 and 1 land in bucket 0, the rest
    // at floor(log2), clamped to the last bucket.
    function automatic int bucket_index(logic [LAT_W-1:0] lat);
        int b;
        b = 0;
        while (lat > LAT_W'(1) && b < BUCKETS - 1) begin
            lat = lat >> 1;
            b++;
        end
        return b;
    endfunction

    // Fold one sample into the statistics; drop it while disabled.
    function automatic void histogram_record(logic [LAT_W-1:0] lat);
        int b;
        b = bucket_index(lat);
        if (hist_enable) begin
            hist_samples = hist_samples + LAT_W'(1);
            hist_total   = hist_total + SUM_W'(lat);
            if (lat > hist_peak)
                hist_peak = lat;
            hist_bins[b] = hist_bins[b] + LAT_W'(1);
        end
    endfunction

    // Compute the answer to a query from the current statistics.
    function automatic t_stats histogram_query(logic [PCT_W-1:0] pct);
        t_stats           s;
        logic [SUM_W-1:0] quotient;
        logic [SUM_W-1:0] rank;
        logic [SUM_W-1:0] running;
        bit               found;
        s.count = hist_samples;
        s.peak  = hist_peak;
        s.mean  = '0;
        s.bound = '0;
        if (hist_samples != '0) begin
            quotient = hist_total / SUM_W'(hist_samples);
            s.mean   = (quotient > SUM_W'(LAT_MAX)) ? LAT_MAX : quotient[LAT_W-1:0];
            // Ceiling of count * pct / 100, never below rank 1.
            rank = (SUM_W'(hist_samples) * SUM_W'(pct) + SUM_W'(RANK_SCALE - 1))
                   / SUM_W'(RANK_SCALE);
            if (rank == '0)
                rank = SUM_W'(1);
            running = '0;
            found   = 1'b0;
            // Fall back to the peak when no bucket reaches the rank.
            s.bound = BOUND_W'(hist_peak);
            for (int i = 0; i < BUCKETS; i++) begin
                if (!found) begin
                    running = running + SUM_W'(hist_bins[i]);
                    if (running >= rank) begin
                        found   = 1'b1;
                        s.bound = BOUND_W'(1) << (i + 1);
                    end
                end
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // Count each accepted transaction and run it through the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_action == ACT_QUERY)
                stats_due.push_back(histogram_query(i_percentile));
            else
                histogram_record(i_latency_ms);
            items_accepted++;
            in_taken = 1'b1;
        end
    end

    // Present the next transaction on the falling edge. Hold valid and
    // payload until accepted; send in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (send_queue.size() > 0) begin
                next_item = send_queue.pop_front();
                i_action     <= next_item.action;
                i_latency_ms <= next_item.latency;
                i_percentile <= next_item.pct;
                i_in_valid   <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // Pick the next burst; one in four has no gap at all.
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver and monitor
    // ------------------------------------------------------------------

    // Stall the output channel on a pattern that changes every so often:
    // open, coin flip, one cycle in five, or almost always blocked.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:  i_out_ready <= 1'b1;
                RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                RX_SLOW:  i_out_ready <= (cycle_count % 5 == 0);
                default:  i_out_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    task automatic check_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each answer with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: unexpected answer: expected none, actual count %0d",
                         $time, o_sample_count);
                errors++;
            end else begin
                want_stats = stats_due.pop_front();
                check_field("sample_count", want_stats.count, o_sample_count);
                check_field("mean_ms", want_stats.mean, o_mean_ms);
                check_field("percentile_bound_ms", want_stats.bound, o_percentile_bound_ms);
                check_field("max_ms", want_stats.peak, o_max_ms);
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** log2_latency_histogram_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_item(logic action, logic [LAT_W-1:0] lat, int pct);
        t_item it;
        it.action  = action;
        it.latency = lat;
        it.pct     = PCT_W'(pct);
        send_queue.push_back(it);
        items_queued++;
    endtask

    // Queue random traffic. Latencies are spread evenly over the buckets
    // by shifting a random word; most percentiles stay in 0..100.
    task automatic random_traffic(int n, int query_pct);
        logic             action;
        logic [LAT_W-1:0] lat;
        int               pct;
        repeat (n) begin
            action = ($urandom_range(1, 100) <= query_pct) ? ACT_QUERY : ACT_RECORD;
            case ($urandom_range(0, 15))
                0:       lat = '0;
                1:       lat = LAT_W'(1);
                2:       lat = LAT_MAX;
                default: lat = $urandom >> $urandom_range(0, LAT_W - 1);
            endcase
            pct = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, 100);
            queue_item(action, lat, pct);
        end
    endtask

    // Wait until every transaction is taken and every answer is in, then
    // give a trailing record time to finish before touching the register.
    task automatic settle();
        wait (items_accepted == items_queued);
        while (stats_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(logic value);
        @(negedge i_clk);
        i_cfg_enable <= value;
        i_cfg_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        hist_enable = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        // Drive every input to a known value and clear the predictor.
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_enable = ENABLE_OFF;
        i_in_valid   = 1'b0;
        i_action     = ACT_RECORD;
        i_latency_ms = '0;
        i_percentile = '0;
        i_out_ready  = 1'b0;
        for (int i = 0; i < BUCKETS; i++)
            hist_bins[i] = '0;
        hist_samples = '0;
        hist_total   = '0;
        hist_peak    = '0;
        hist_enable  = ENABLE_OFF;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled after reset: queries on an empty histogram answer zero,
        // and a record must be dropped.
        queue_item(ACT_QUERY, LAT_MAX, 50);
        queue_item(ACT_RECORD, 1000, 127);
        queue_item(ACT_QUERY, '0, 100);
        settle();

        write_enable(ENABLE_ON);

        // Bucket edges: 0 and 1 share bucket 0, 2 and 3 bucket 1, the top
        // values land in the last two buckets. Unused fields carry junk.
        queue_item(ACT_RECORD, '0, 127);
        queue_item(ACT_RECORD, 1, 0);
        queue_item(ACT_RECORD, 2, 85);
        queue_item(ACT_RECORD, 3, 42);
        queue_item(ACT_RECORD, LAT_MAX, 127);
        queue_item(ACT_RECORD, 32'h8000_0000, 1);
        queue_item(ACT_RECORD, 32'h7FFF_FFFF, 100);
        queue_item(ACT_RECORD, 1024, 64);
        // Percentile zero rounds up to rank one; above one hundred falls
        // back to the peak.
        queue_item(ACT_QUERY, LAT_MAX, 0);
        queue_item(ACT_QUERY, 32'h5555_5555, 1);
        queue_item(ACT_QUERY, 32'hAAAA_AAAA, 50);
        queue_item(ACT_QUERY, 7, 99);
        queue_item(ACT_QUERY, '0, 100);
        queue_item(ACT_QUERY, 1, 101);
        queue_item(ACT_QUERY, LAT_MAX, 127);
        settle();

        random_traffic(450, 40);
        settle();

        // Disabled again: records drop, queries still answer.
        write_enable(ENABLE_OFF);
        random_traffic(150, 50);
        settle();

        write_enable(ENABLE_ON);
        random_traffic(450, 40);
        settle();

        if (errors == 0)
            $display("** log2_latency_histogram_top: PASSED **");
        else
            $display("** log2_latency_histogram_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/l2lh_pkg.sv
rtl/log2_latency_histogram_top.sv
sim/testbench.sv
